FILE: rtl/mbsm_pkg.sv
// Shared types for the memory bank sort and merge block.
// Command flags passed from the front end to the back end, and back-end states.
// No dependencies.
package mbsm_pkg;

	// What one queued command asks the back end to do
	typedef struct packed {
		logic store;  // write the bank into its slot
		logic fin;    // set is closed: sort, merge, emit
	} mbsm_op_t;

	// Back-end sequencer states
	typedef enum logic [3:0] {
		B_IDLE,
		B_SORT_LD,
		B_SORT_CMP,
		B_SORT_WRA,
		B_MRG_RD0,
		B_MRG_LD,
		B_MRG_CMP,
		B_MRG_WR,
		B_EMIT_RD,
		B_EMIT,
		B_EMPTY
	} mbsm_state_t;

endpackage

FILE: rtl/mbsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbsm_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/mbsm_front.sv
// Front end: accepts items, tracks set fill and list end, classifies items.
// Depends on mbsm_pkg.
module mbsm_front #(
	parameter int MAX_BANKS = 8,
	parameter int ADDR_BITS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               full,
	output logic                               busy,
	input  logic [ADDR_BITS-1:0]               bank_start,
	input  logic [ADDR_BITS-1:0]               bank_length,
	input  logic                               final_item,
	output logic                               push,
	output mbsm_pkg::mbsm_op_t                 cmd_op,
	output logic [$clog2(MAX_BANKS)-1:0]       cmd_slot,
	output logic [$clog2(MAX_BANKS+1)-1:0]     cmd_count,
	output logic [ADDR_BITS-1:0]               cmd_start,
	output logic [ADDR_BITS-1:0]               cmd_len
);
	import mbsm_pkg::*;

	localparam int IW = $clog2(MAX_BANKS);
	localparam int CW = $clog2(MAX_BANKS + 1);

	logic          closed_q;
	logic [CW-1:0] held_q;
	logic          accept;
	logic          do_store;
	logic          do_close;

	// Classify the incoming item
	assign busy     = full;
	assign accept   = start && !full;
	assign do_close = !closed_q && (bank_length == '0);
	assign do_store = !closed_q && (bank_length != '0) && (held_q < CW'(MAX_BANKS));

	assign cmd_op.store = do_store;
	assign cmd_op.fin   = final_item;
	assign cmd_slot     = held_q[IW-1:0];
	assign cmd_count    = held_q + CW'(do_store);
	assign cmd_start    = bank_start;
	assign cmd_len      = bank_length;
	assign push         = accept && (do_store || final_item);

	// Set bookkeeping: fill count and list-end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			held_q   <= '0;
		end else if (accept) begin
			if (final_item) begin
				closed_q <= 1'b0;
				held_q   <= '0;
			end else begin
				if (do_close) begin
					closed_q <= 1'b1;
				end
				if (do_store) begin
					held_q <= held_q + 1'b1;
				end
			end
		end
	end

endmodule

FILE: rtl/mbsm_queue.sv
// Two-entry command queue between front and back end.
// No dependencies.
module mbsm_queue #(
	parameter int WIDTH = 140
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] ent_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = ent_q[rd_q];

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= wdata;
		end
	end

	// Pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/mbsm_back.sv
// Back end: stores banks, exchange-sorts and merges them in the bank RAM,
// then emits the merged list. Depends on mbsm_pkg and mbsm_ram.
module mbsm_back #(
	parameter int MAX_BANKS = 8,
	parameter int ADDR_BITS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           pop,
	input  mbsm_pkg::mbsm_op_t             cmd_op,
	input  logic [$clog2(MAX_BANKS)-1:0]   cmd_slot,
	input  logic [$clog2(MAX_BANKS+1)-1:0] cmd_count,
	input  logic [ADDR_BITS-1:0]           cmd_start,
	input  logic [ADDR_BITS-1:0]           cmd_len,
	output logic                           out_valid,
	output logic [ADDR_BITS-1:0]           out_start,
	output logic [ADDR_BITS-1:0]           out_length,
	output logic [2:0]                     out_index,
	output logic [3:0]                     out_count,
	output logic                           out_last
);
	import mbsm_pkg::*;

	localparam int IW = $clog2(MAX_BANKS);
	localparam int CW = $clog2(MAX_BANKS + 1);

	mbsm_state_t           state_q, state_d;
	logic [CW-1:0]         n_q, i_q, j_q, k_q;
	logic [ADDR_BITS-1:0]  cur_start_q, cur_len_q;

	logic                  ram_we;
	logic [IW-1:0]         ram_waddr, ram_raddr;
	logic [2*ADDR_BITS-1:0] ram_wdata, ram_rdata;
	logic [ADDR_BITS-1:0]  rd_start, rd_len;

	logic                  swap, adj, j_end, i_end;
	logic [CW+3:0]         j_ext, n_ext;

	assign rd_start = ram_rdata[2*ADDR_BITS-1:ADDR_BITS];
	assign rd_len   = ram_rdata[ADDR_BITS-1:0];

	// Exchange and adjacency tests against the held bank
	assign swap  = cur_start_q > rd_start;
	assign adj   = rd_start == (cur_start_q + cur_len_q);
	assign j_end = CW'(j_q + 1'b1) == n_q;
	assign i_end = CW'(i_q + 2'd2) == n_q;
	assign j_ext = {4'b0, j_q};
	assign n_ext = {4'b0, n_q};

	mbsm_ram #(
		.WIDTH(2 * ADDR_BITS),
		.DEPTH(MAX_BANKS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, RAM port control, queue pop
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = {cur_start_q, cur_len_q};
		ram_raddr = '0;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					if (cmd_op.store) begin
						ram_we    = 1'b1;
						ram_waddr = cmd_slot;
						ram_wdata = {cmd_start, cmd_len};
					end
					if (cmd_op.fin) begin
						if (cmd_count == '0) begin
							state_d = B_EMPTY;
						end else if (cmd_count == CW'(1)) begin
							state_d = B_MRG_RD0;
						end else begin
							state_d = B_SORT_LD;
						end
					end
				end
			end
			B_SORT_LD: begin
				ram_raddr = i_q[IW-1:0] + 1'b1;
				state_d   = B_SORT_CMP;
			end
			B_SORT_CMP: begin
				if (swap) begin
					ram_we    = 1'b1;
					ram_waddr = j_q[IW-1:0];
				end
				if (j_end) begin
					state_d = B_SORT_WRA;
				end else begin
					ram_raddr = j_q[IW-1:0] + 1'b1;
				end
			end
			B_SORT_WRA: begin
				ram_we    = 1'b1;
				ram_waddr = i_q[IW-1:0];
				if (i_end) begin
					state_d = B_MRG_RD0;
				end else begin
					ram_raddr = i_q[IW-1:0] + 1'b1;
					state_d   = B_SORT_LD;
				end
			end
			B_MRG_RD0: begin
				state_d = B_MRG_LD;
			end
			B_MRG_LD: begin
				if (n_q == CW'(1)) begin
					state_d = B_MRG_WR;
				end else begin
					ram_raddr = IW'(1);
					state_d   = B_MRG_CMP;
				end
			end
			B_MRG_CMP: begin
				if (!adj) begin
					ram_we    = 1'b1;
					ram_waddr = k_q[IW-1:0];
				end
				if (j_end) begin
					state_d = B_MRG_WR;
				end else begin
					ram_raddr = j_q[IW-1:0] + 1'b1;
				end
			end
			B_MRG_WR: begin
				ram_we    = 1'b1;
				ram_waddr = k_q[IW-1:0];
				state_d   = B_EMIT_RD;
			end
			B_EMIT_RD: begin
				state_d = B_EMIT;
			end
			B_EMIT: begin
				if (j_end) begin
					state_d = B_IDLE;
				end else begin
					ram_raddr = j_q[IW-1:0] + 1'b1;
				end
			end
			B_EMPTY: begin
				state_d = B_IDLE;
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// Counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (pop && cmd_op.fin) begin
						n_q <= cmd_count;
						i_q <= '0;
					end
				end
				B_SORT_LD:  j_q <= i_q + 1'b1;
				B_SORT_CMP: j_q <= j_q + 1'b1;
				B_SORT_WRA: i_q <= i_q + 1'b1;
				B_MRG_LD: begin
					j_q <= CW'(1);
					k_q <= '0;
				end
				B_MRG_CMP: begin
					j_q <= j_q + 1'b1;
					if (!adj) begin
						k_q <= k_q + 1'b1;
					end
				end
				B_MRG_WR:  n_q <= k_q + 1'b1;
				B_EMIT_RD: j_q <= '0;
				B_EMIT:    j_q <= j_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Held bank: current sort candidate or merge accumulator
	always_ff @(posedge clk) begin
		case (state_q) inside
			B_SORT_LD, B_MRG_LD: begin
				cur_start_q <= rd_start;
				cur_len_q   <= rd_len;
			end
			B_SORT_CMP: begin
				if (swap) begin
					cur_start_q <= rd_start;
					cur_len_q   <= rd_len;
				end
			end
			B_MRG_CMP: begin
				if (adj) begin
					cur_len_q <= cur_len_q + rd_len;
				end else begin
					cur_start_q <= rd_start;
					cur_len_q   <= rd_len;
				end
			end
			default: ;
		endcase
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= (state_q == B_EMIT) || (state_q == B_EMPTY);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == B_EMIT) begin
			out_start  <= rd_start;
			out_length <= rd_len;
			out_index  <= j_ext[2:0];
			out_count  <= n_ext[3:0];
			out_last   <= j_end;
		end else if (state_q == B_EMPTY) begin
			out_start  <= '0;
			out_length <= '0;
			out_index  <= '0;
			out_count  <= '0;
			out_last   <= 1'b1;
		end
	end

endmodule

FILE: rtl/memory_bank_sort_merge.sv
// Top level of the memory bank sort and merge block.
// Depends on mbsm_pkg, mbsm_front, mbsm_queue, mbsm_back (and mbsm_ram).
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  input    | start & !busy accepts     | bank_start, bank_length, final_item
//  result   | out_valid, one cycle each | out_start, out_length, out_index,
//           |                           | out_count, out_last
//
// The front end takes one item per cycle while the two-entry queue has room. A final
// item with n stored banks merging to m occupies the back end through the exchange
// sort and merge passes in the bank RAM, and no further command is popped meanwhile;
// the m results leave one per cycle at the end of that span (one all-zero result for
// an empty set).
// busy is high while the queue is full. All control state clears on reset.
// The result side cannot stall: each result shows for exactly one cycle.
module memory_bank_sort_merge #(
	parameter int MAX_BANKS = 8,
	parameter int ADDR_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ADDR_BITS-1:0] bank_start,
	input  logic [ADDR_BITS-1:0] bank_length,
	input  logic                 final_item,
	output logic                 out_valid,
	output logic [ADDR_BITS-1:0] out_start,
	output logic [ADDR_BITS-1:0] out_length,
	output logic [2:0]           out_index,
	output logic [3:0]           out_count,
	output logic                 out_last
);
	import mbsm_pkg::*;

	localparam int IW = $clog2(MAX_BANKS);
	localparam int CW = $clog2(MAX_BANKS + 1);
	localparam int QW = 2 + IW + CW + 2 * ADDR_BITS;

	logic                 push, pop, q_full, q_empty;
	mbsm_op_t             f_op, b_op;
	logic [IW-1:0]        f_slot, b_slot;
	logic [CW-1:0]        f_count, b_count;
	logic [ADDR_BITS-1:0] f_start, f_len, b_start, b_len;
	logic [QW-1:0]        q_wdata, q_rdata;

	mbsm_front #(
		.MAX_BANKS(MAX_BANKS),
		.ADDR_BITS(ADDR_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.full       (q_full),
		.busy       (busy),
		.bank_start (bank_start),
		.bank_length(bank_length),
		.final_item (final_item),
		.push       (push),
		.cmd_op     (f_op),
		.cmd_slot   (f_slot),
		.cmd_count  (f_count),
		.cmd_start  (f_start),
		.cmd_len    (f_len)
	);

	// Pack and unpack commands around the queue
	assign q_wdata = {f_op, f_slot, f_count, f_start, f_len};
	assign {b_op, b_slot, b_count, b_start, b_len} = q_rdata;

	mbsm_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (q_wdata),
		.pop   (pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	mbsm_back #(
		.MAX_BANKS(MAX_BANKS),
		.ADDR_BITS(ADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.cmd_op    (b_op),
		.cmd_slot  (b_slot),
		.cmd_count (b_count),
		.cmd_start (b_start),
		.cmd_len   (b_len),
		.out_valid (out_valid),
		.out_start (out_start),
		.out_length(out_length),
		.out_index (out_index),
		.out_count (out_count),
		.out_last  (out_last)
	);

endmodule

FILE: rtl/mbsm_checker.sv
// Port-level checks on the result stream of memory_bank_sort_merge.
// Bound to the top level below; no package dependencies.
module mbsm_checker #(
	parameter int ADDR_BITS = 64
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic [ADDR_BITS-1:0] out_start,
	input logic [ADDR_BITS-1:0] out_length,
	input logic [2:0]           out_index,
	input logic [3:0]           out_count,
	input logic                 out_last
);

	// A set's results come back to back, indexes counting up, count steady
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |=> out_valid && out_index == $past(out_index) + 3'd1
			&& out_count == $past(out_count))
		else $error("result run broken");

	// Merged list leaves in ascending start order
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |=> out_start >= $past(out_start))
		else $error("results not sorted by start");

	// No result follows directly on the last result of a set
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last |=> !out_valid)
		else $error("result right after last");

	// Empty set gives one all-zero result
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_count == 4'd0 |-> out_last && out_index == 3'd0
			&& out_start == '0 && out_length == '0)
		else $error("bad empty-set result");

	// Last result of a non-empty set carries index count-1
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last && out_count != 4'd0 |-> out_index == 3'(out_count - 4'd1))
		else $error("last index does not match count");

endmodule

bind memory_bank_sort_merge mbsm_checker #(.ADDR_BITS(ADDR_BITS)) u_mbsm_checker (.*);
